// File: hw/rtl/grrp_pkg.sv
// Shared types and constants for the greedy rectangle row placement block.
`timescale 1ns / 1ps
`default_nettype none

package grrp_pkg;

  // Placement spot codes as reported in each result.
  typedef enum logic [1:0] {
    SPOT_RIGHT  = 2'd0,
    SPOT_SUBROW = 2'd1,
    SPOT_BLOCK  = 2'd2,
    SPOT_ROW    = 2'd3
  } spot_t;

  // Configuration register indexes.
  localparam logic CFG_TARGET_WIDTH = 1'b0;
  localparam logic CFG_SEPARATION   = 1'b1;

  localparam logic [30:0] TARGET_WIDTH_RESET = 31'd1024;
  localparam logic [15:0] SEPARATION_RESET   = 16'd0;

  // Slots of the placement cursor.
  localparam int ST_ROW_TOP        = 0;
  localparam int ST_ROW_HEIGHT     = 1;
  localparam int ST_ROW_RIGHT_EDGE = 2;
  localparam int ST_BLOCK_LEFT     = 3;
  localparam int ST_SUBROW_TOP     = 4;
  localparam int ST_SUBROW_HEIGHT  = 5;
  localparam int ST_SUBROW_NEXT_X  = 6;
  localparam int ST_EXTENT_WIDTH   = 7;
  localparam int ST_EXTENT_HEIGHT  = 8;
  localparam int NUM_ST            = 9;

  typedef struct packed {
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic        first_rect;
  } in_item_t;

  typedef struct packed {
    spot_t       spot;
    logic [30:0] pos_x;
    logic [30:0] pos_y;
    logic [30:0] drawing_width;
    logic [30:0] drawing_height;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/grrp_place.sv
// Placement step: next cursor and result for one rectangle, all combinational.
`timescale 1ns / 1ps
`default_nettype none

module grrp_place
  import grrp_pkg::*;
#(
  parameter int COORD_BITS = 48,
  parameter int SAT_LIMIT  = 2147483647
) (
  input  logic [NUM_ST-1:0][COORD_BITS-1:0] cur,
  input  logic [30:0]                       row_limit,
  input  logic [15:0]                       separation,
  input  in_item_t                          item,
  output logic [NUM_ST-1:0][COORD_BITS-1:0] nxt,
  output out_item_t                         result
);

  localparam int CW = COORD_BITS;

  function automatic logic [CW-1:0] sadd(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] umax(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [30:0] outsat(input logic [CW-1:0] v);
    return (v > CW'(SAT_LIMIT)) ? 31'(SAT_LIMIT) : v[30:0];
  endfunction

  logic [CW-1:0] w, h, sep, tw;
  logic [CW-1:0] rt, rh, rre, bl, st, sh, snx, ew, eh;
  logic [CW-1:0] n_rt, n_rh, n_rre, n_bl, n_st, n_sh, n_snx;
  logic [CW-1:0] blk_left, x, xw, depth;
  spot_t         spot;

  always_comb begin
    w   = CW'(item.rect_width);
    h   = CW'(item.rect_height);
    sep = CW'(separation);
    tw  = CW'(row_limit);

    rt  = cur[ST_ROW_TOP];
    rh  = cur[ST_ROW_HEIGHT];
    rre = cur[ST_ROW_RIGHT_EDGE];
    bl  = cur[ST_BLOCK_LEFT];
    st  = cur[ST_SUBROW_TOP];
    sh  = cur[ST_SUBROW_HEIGHT];
    snx = cur[ST_SUBROW_NEXT_X];
    ew  = cur[ST_EXTENT_WIDTH];
    eh  = cur[ST_EXTENT_HEIGHT];

    // A new block is only worth opening when the cursor sits below row level.
    blk_left = sadd(rre, sep);
    if ((st > rt) && (sadd(blk_left, w) <= tw)) begin
      spot = SPOT_BLOCK;
    end else if (sadd(snx, w) <= tw) begin
      spot = SPOT_RIGHT;
    end else if (sadd(bl, w) <= tw) begin
      spot = SPOT_SUBROW;
    end else begin
      spot = SPOT_ROW;
    end

    n_rt  = rt;
    n_rh  = rh;
    n_rre = rre;
    n_bl  = bl;
    n_st  = st;
    n_sh  = sh;
    n_snx = snx;
    case (spot)
      SPOT_RIGHT: begin
        n_sh = umax(sh, h);
      end
      SPOT_SUBROW: begin
        n_st  = sadd(sadd(st, sh), sep);
        n_sh  = h;
        n_snx = bl;
      end
      SPOT_BLOCK: begin
        n_bl  = blk_left;
        n_st  = rt;
        n_sh  = h;
        n_snx = blk_left;
      end
      default: begin
        n_rt  = sadd(sadd(rt, rh), sep);
        n_rh  = '0;
        n_rre = '0;
        n_bl  = '0;
        n_st  = n_rt;
        n_sh  = h;
        n_snx = '0;
      end
    endcase

    x     = n_snx;
    xw    = sadd(x, w);
    depth = (n_st > n_rt) ? (n_st - n_rt) : '0;

    nxt[ST_ROW_TOP]        = n_rt;
    nxt[ST_ROW_HEIGHT]     = umax(n_rh, sadd(depth, h));
    nxt[ST_ROW_RIGHT_EDGE] = umax(n_rre, xw);
    nxt[ST_BLOCK_LEFT]     = n_bl;
    nxt[ST_SUBROW_TOP]     = n_st;
    nxt[ST_SUBROW_HEIGHT]  = n_sh;
    nxt[ST_SUBROW_NEXT_X]  = sadd(xw, sep);
    nxt[ST_EXTENT_WIDTH]   = umax(ew, xw);
    nxt[ST_EXTENT_HEIGHT]  = umax(eh, sadd(n_st, h));

    result.spot  = spot;
    result.pos_x = outsat(x);
    result.pos_y = outsat(n_st);

    // The first rectangle of a drawing seeds the cursor at the origin.
    if (item.first_rect) begin
      nxt[ST_ROW_TOP]        = '0;
      nxt[ST_ROW_HEIGHT]     = h;
      nxt[ST_ROW_RIGHT_EDGE] = w;
      nxt[ST_BLOCK_LEFT]     = '0;
      nxt[ST_SUBROW_TOP]     = '0;
      nxt[ST_SUBROW_HEIGHT]  = h;
      nxt[ST_SUBROW_NEXT_X]  = sadd(w, sep);
      nxt[ST_EXTENT_WIDTH]   = w;
      nxt[ST_EXTENT_HEIGHT]  = h;
      result.spot            = SPOT_ROW;
      result.pos_x           = '0;
      result.pos_y           = '0;
    end

    result.drawing_width  = outsat(nxt[ST_EXTENT_WIDTH]);
    result.drawing_height = outsat(nxt[ST_EXTENT_HEIGHT]);
  end

endmodule

`default_nettype wire

// File: hw/rtl/greedy_rect_row_placement.sv
// Top level of the greedy rectangle row placement block.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the input channel carries one rectangle; the block places it
// greedily (new block at row level, right of its predecessor, new subrow, or new
// row, whichever first keeps the row within the configured row width limit) and
// returns exactly one result transfer with the chosen spot, the top-left corner
// and the running drawing extents, all saturated at SAT_LIMIT. The block takes
// one rectangle per clock cycle unless the output is stalled, and the result is
// registered and appears in the cycle after the input transfer. The placement
// cursor allows this: its nine coordinates are read and rewritten in the same
// cycle, so one rectangle's fit tests and cursor update close together. A single
// output register holds each result; while it is full and stalled, the input is
// stalled as well, and a new rectangle is taken in the same cycle that the held
// result is transferred. Internal coordinates are COORD_BITS wide and saturate
// at their all-ones value. Configuration (row width limit, separation) is written
// through cfg_write/cfg_index/cfg_data and must only change while no rectangle is
// in flight. A rectangle with first_rect set starts a new drawing at the origin.

module greedy_rect_row_placement
  import grrp_pkg::*;
#(
  parameter int COORD_BITS = 48,
  parameter int SAT_LIMIT  = 2147483647
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [30:0] row_limit;
  logic [15:0] separation;

  logic [NUM_ST-1:0][COORD_BITS-1:0] cursor;
  logic [NUM_ST-1:0][COORD_BITS-1:0] cursor_next;
  out_item_t                         result_next;

  logic in_accept;

  // The input waits only while a finished result is held and not yet taken.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  grrp_place #(
    .COORD_BITS(COORD_BITS),
    .SAT_LIMIT (SAT_LIMIT)
  ) u_place (
    .cur       (cursor),
    .row_limit (row_limit),
    .separation(separation),
    .item      (in_data),
    .nxt       (cursor_next),
    .result    (result_next)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit  <= TARGET_WIDTH_RESET;
      separation <= SEPARATION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET_WIDTH: row_limit  <= cfg_data;
        CFG_SEPARATION:   separation <= cfg_data[15:0];
      endcase
    end
  end

  // Placement cursor and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        cursor <= cursor_next;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result_next;
    end
  end

  // Every accepted rectangle yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted rectangle produced no result");

  // A new drawing always starts as a new row at the origin.
  a_first_at_origin: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.first_rect |=>
      out_data.spot == SPOT_ROW && out_data.pos_x == '0 && out_data.pos_y == '0)
    else $error("first rectangle not placed at the origin");

  // The running extents always cover the corner just placed.
  a_extent_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.drawing_width >= out_data.pos_x &&
                  out_data.drawing_height >= out_data.pos_y)
    else $error("drawing extents smaller than placed position");

endmodule

`default_nettype wire

// File: dv/greedy_rect_row_placement_test.sv
// Self-checking testbench for the greedy rectangle row placement block.
`timescale 1ns / 1ps

module greedy_rect_row_placement_test;
  import grrp_pkg::*;

  // The cursor model keeps coordinates in 64-bit containers and saturates them at the
  // block's 48-bit all-ones value. Results are clamped to the 31-bit output limit.
  typedef logic [63:0] coord_t;
  localparam coord_t COORD_ALL_ONES = 64'h0000_FFFF_FFFF_FFFF;
  localparam coord_t OUT_LIMIT = 64'd2147483647;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 300;

  // Placement model plus the queue of results that the block still owes.
  class placement_scoreboard;
    coord_t row_limit;
    coord_t spacing;
    coord_t row_top, row_height, row_edge, block_left;
    coord_t sub_top, sub_height, sub_next;
    coord_t ext_w, ext_h;
    out_item_t owed_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned spot_hits[4];
    int unsigned y_saturated;

    function new();
      row_limit = coord_t'(TARGET_WIDTH_RESET);
      spacing = coord_t'(SEPARATION_RESET);
      row_top = '0;
      row_height = '0;
      row_edge = '0;
      block_left = '0;
      sub_top = '0;
      sub_height = '0;
      sub_next = '0;
      ext_w = '0;
      ext_h = '0;
      errors = 0;
      checked = 0;
      y_saturated = 0;
      foreach (spot_hits[i]) spot_hits[i] = 0;
    endfunction

    function coord_t sat_add(coord_t a, coord_t b);
      if (a > COORD_ALL_ONES) a = COORD_ALL_ONES;
      if (b > COORD_ALL_ONES) b = COORD_ALL_ONES;
      if (b > COORD_ALL_ONES - a) return COORD_ALL_ONES;
      return a + b;
    endfunction

    function coord_t larger(coord_t a, coord_t b);
      return (a > b) ? a : b;
    endfunction

    function logic [30:0] clamp_out(coord_t v);
      return (v > OUT_LIMIT) ? OUT_LIMIT[30:0] : v[30:0];
    endfunction

    function void set_regs(logic [30:0] tw, logic [15:0] sep);
      row_limit = coord_t'(tw);
      spacing = coord_t'(sep);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Place one accepted rectangle and queue the result it must produce.
    function void note_rect(in_item_t r);
      coord_t w, h, x, depth;
      spot_t spot;
      out_item_t want;
      w = coord_t'(r.rect_width);
      h = coord_t'(r.rect_height);
      if (r.first_rect) begin
        row_top = '0;
        row_height = h;
        row_edge = w;
        block_left = '0;
        sub_top = '0;
        sub_height = h;
        sub_next = sat_add(w, spacing);
        ext_w = w;
        ext_h = h;
        spot = SPOT_ROW;
        x = '0;
      end else begin
        if (sub_top > row_top && sat_add(sat_add(row_edge, spacing), w) <= row_limit) begin
          spot = SPOT_BLOCK;
        end else if (sat_add(sub_next, w) <= row_limit) begin
          spot = SPOT_RIGHT;
        end else if (sat_add(block_left, w) <= row_limit) begin
          spot = SPOT_SUBROW;
        end else begin
          spot = SPOT_ROW;
        end
        case (spot)
          SPOT_RIGHT: begin
            sub_height = larger(sub_height, h);
          end
          SPOT_SUBROW: begin
            sub_top = sat_add(sat_add(sub_top, sub_height), spacing);
            sub_height = h;
            sub_next = block_left;
          end
          SPOT_BLOCK: begin
            block_left = sat_add(row_edge, spacing);
            sub_top = row_top;
            sub_height = h;
            sub_next = block_left;
          end
          default: begin
            row_top = sat_add(sat_add(row_top, row_height), spacing);
            row_height = '0;
            row_edge = '0;
            block_left = '0;
            sub_top = row_top;
            sub_height = h;
            sub_next = '0;
          end
        endcase
        x = sub_next;
        sub_next = sat_add(sat_add(x, w), spacing);
        row_edge = larger(row_edge, sat_add(x, w));
        depth = (sub_top > row_top) ? sub_top - row_top : '0;
        row_height = larger(row_height, sat_add(depth, h));
        ext_w = larger(ext_w, sat_add(x, w));
        ext_h = larger(ext_h, sat_add(sub_top, h));
      end
      want.spot = spot;
      want.pos_x = clamp_out(x);
      want.pos_y = clamp_out(sub_top);
      want.drawing_width = clamp_out(ext_w);
      want.drawing_height = clamp_out(ext_h);
      spot_hits[spot]++;
      if (sub_top > OUT_LIMIT) y_saturated++;
      owed_q.push_back(want);
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compare one result from the block against the oldest owed result.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        flag("unexpected result, spot", 0, got.spot);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.spot !== want.spot) flag("spot", want.spot, got.spot);
      if (got.pos_x !== want.pos_x) flag("pos_x", want.pos_x, got.pos_x);
      if (got.pos_y !== want.pos_y) flag("pos_y", want.pos_y, got.pos_y);
      if (got.drawing_width !== want.drawing_width) begin
        flag("drawing_width", want.drawing_width, got.drawing_width);
      end
      if (got.drawing_height !== want.drawing_height) begin
        flag("drawing_height", want.drawing_height, got.drawing_height);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  placement_scoreboard sb = new();

  // Knobs and counters for the stimulus thread, the result-side stall process and the watchdog.
  bit          tx_noisy;
  bit          rx_noisy;
  bit          hold_req;
  int          stall_left;
  int unsigned cycle_count;
  int unsigned rects_sent;
  int unsigned settings_used;

  greedy_rect_row_placement u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Every result transfer is checked at the edge where it happens.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Gap length for either side: mostly none, often a short one, now and then a long one.
  function automatic int pick_idle(bit noisy);
    int unsigned p;
    if (!noisy) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Result-side stall driver. A hold request keeps out_stall high for a long, counted
  // stretch so that the single output register fills and the block stalls its input.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0) begin
        stall_left = pick_idle(rx_noisy);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t mk_rect(int unsigned w, int unsigned h, bit first);
    in_item_t r;
    r.rect_width = w[15:0];
    r.rect_height = h[15:0];
    r.first_rect = first;
    return r;
  endfunction

  // Random rectangle sized against the row limit, so that most of them land in the
  // interesting spots. A tall rectangle drives the drawing downward toward the
  // output saturation limit.
  function automatic in_item_t random_rect(logic [30:0] tw, bit tall);
    int unsigned p, cap;
    in_item_t r;
    if (tall) return mk_rect($urandom, $urandom_range(60000, 65535), 1'b0);
    cap = (tw > 31'd65535) ? 65535 : int'(tw);
    p = $urandom_range(0, 99);
    if (p < 70) begin
      r = mk_rect($urandom_range(0, cap / 3), $urandom_range(0, 255), 1'b0);
    end else if (p < 90) begin
      r = mk_rect($urandom_range(0, cap), $urandom_range(0, 65535), 1'b0);
    end else begin
      r = mk_rect($urandom, $urandom, 1'b0);
    end
    r.first_rect = ($urandom_range(0, 99) < 3);
    return r;
  endfunction

  // Offer one rectangle and hold it until the block takes it. If a gap follows, valid
  // drops for the length of that gap; otherwise the next call keeps valid high.
  task automatic send_rect(input in_item_t r);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_rect(r);
    rects_sent++;
    gap = pick_idle(tx_noisy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and let every owed result come back before the registers move.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both registers are written back to back; the block is idle at this point.
  task automatic set_config(input logic [30:0] tw, input logic [15:0] sep);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TARGET_WIDTH;
    cfg_data <= tw;
    @(posedge clk);
    cfg_index <= CFG_SEPARATION;
    cfg_data <= {15'd0, sep};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_regs(tw, sep);
    settings_used++;
  endtask

  task automatic run_phase(input logic [30:0] tw, input logic [15:0] sep, input int count,
                           input bit noisy, input bit hold, input bit tall);
    set_config(tw, sep);
    tx_noisy = noisy;
    rx_noisy = noisy;
    if (hold) hold_req = 1'b1;
    repeat (count) send_rect(random_rect(tw, tall));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_TARGET_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    tx_noisy = 1'b1;
    rx_noisy = 1'b1;
    hold_req = 1'b0;
    cycle_count = 0;
    rects_sent = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset register values (target 1024, no separation).
    // The first two rectangles arrive before any drawing has been started.
    send_rect(mk_rect(10, 5, 1'b0));
    send_rect(mk_rect(0, 0, 1'b0));
    // A fresh drawing, then a rectangle that no longer fits on the right and opens a
    // subrow below, then one that fits as a new block beside the deeper block.
    send_rect(mk_rect(400, 50, 1'b1));
    send_rect(mk_rect(700, 30, 1'b0));
    send_rect(mk_rect(200, 10, 1'b0));
    send_rect(mk_rect(100, 10, 1'b0));
    // Exactly the limit wide: only a new row takes it.
    send_rect(mk_rect(1024, 5, 1'b0));
    // Wider than the limit, then the field extremes.
    send_rect(mk_rect(2000, 7, 1'b0));
    send_rect(mk_rect(65535, 65535, 1'b0));
    send_rect(mk_rect(0, 65535, 1'b0));
    send_rect(mk_rect(65535, 0, 1'b0));
    send_rect(mk_rect(0, 0, 1'b1));
    send_rect(mk_rect(65535, 65535, 1'b1));
    send_rect(mk_rect(1, 1, 1'b0));
    drain();

    // Register extremes: zero limit with the widest separation, then the widest limit.
    set_config(31'd0, 16'hFFFF);
    send_rect(mk_rect(0, 0, 1'b1));
    send_rect(mk_rect(0, 3, 1'b0));
    send_rect(mk_rect(5, 65535, 1'b0));
    drain();
    set_config(31'h7FFF_FFFF, 16'hFFFF);
    send_rect(mk_rect(65535, 1, 1'b1));
    send_rect(mk_rect(65535, 2, 1'b0));
    send_rect(mk_rect(65535, 65535, 1'b0));
    send_rect(mk_rect(0, 0, 1'b0));
    drain();

    // Random part over a range of settings. The second phase carries the long
    // result-side hold while the sender keeps offering rectangles.
    run_phase(31'd1024, 16'd0, 240, 1'b1, 1'b0, 1'b0);
    run_phase(31'd300, 16'd5, 240, 1'b1, 1'b1, 1'b0);
    run_phase(31'd0, 16'd0, 120, 1'b1, 1'b0, 1'b0);
    run_phase(31'h7FFF_FFFF, 16'hFFFF, 240, 1'b0, 1'b0, 1'b0);
    run_phase(31'd5000, 16'($urandom_range(0, 64)), 240, 1'b1, 1'b0, 1'b0);
    run_phase(31'd64, 16'd1, 240, 1'b1, 1'b0, 1'b0);
    run_phase(31'($urandom), 16'($urandom), 240, 1'b1, 1'b0, 1'b0);
    run_phase(31'd100000, 16'd300, 300, 1'b1, 1'b0, 1'b0);

    // With a zero limit every tall rectangle opens a new row below the last one, so
    // the drawing grows by close to two full heights per transfer, back to back.
    run_phase(31'd0, 16'hFFFF, 40, 1'b0, 1'b0, 1'b1);

    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.flag("results never returned", sb.pending(), 0);

    $display("Placed %0d rectangles under %0d register settings, %0d results checked.",
             rects_sent, settings_used, sb.checked);
    $display("Spots right/subrow/block/row: %0d/%0d/%0d/%0d; saturated tops: %0d.",
             sb.spot_hits[SPOT_RIGHT], sb.spot_hits[SPOT_SUBROW], sb.spot_hits[SPOT_BLOCK],
             sb.spot_hits[SPOT_ROW], sb.y_saturated);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
